[rtl/bbp_pkg.sv]
// Shared constants, register map and controller/datapath command types.
package bbp_pkg;

    localparam int SAMPLE_WIDTH_DEF = 24;
    localparam int STATE_WIDTH_DEF  = 40;
    localparam int COEF_WIDTH       = 32;
    localparam int COEF_FRAC        = 28;
    localparam int TAP_COUNT        = 4;
    localparam int TAP_IDX_WIDTH    = $clog2(TAP_COUNT);
    localparam int REG_COUNT        = 5;
    localparam int REG_IDX_WIDTH    = 3;
    localparam int PADDR_WIDTH      = 5;
    localparam int PDATA_WIDTH      = 32;

    typedef logic signed [COEF_WIDTH-1:0] coef_t;

    // Register indexes (byte address is 4 * index)
    localparam logic [REG_IDX_WIDTH-1:0] REG_GAIN      = 3'd0;
    localparam logic [REG_IDX_WIDTH-1:0] REG_FB_ONE    = 3'd1;
    localparam logic [REG_IDX_WIDTH-1:0] REG_FB_TWO    = 3'd2;
    localparam logic [REG_IDX_WIDTH-1:0] REG_FB_THREE  = 3'd3;
    localparam logic [REG_IDX_WIDTH-1:0] REG_FB_FOUR   = 3'd4;

    // Command from the sequencer to the datapath, one per cycle
    typedef struct packed {
        logic                     load;      // capture a new sample transaction
        logic                     mul_en;    // issue one half product
        logic                     mul_gain;  // gain times difference term
        logic [TAP_IDX_WIDTH-1:0] mul_tap;   // feedback tap when not gain
        logic                     mul_hi;    // upper half of the operand
        logic                     finish;    // close the recursion, shift delay line
    } bbp_cmd_t;

    // Status from the datapath back to the sequencer
    typedef struct packed {
        logic out_full;
    } bbp_sts_t;

endpackage

[rtl/bbp_if.sv]
// Stream interfaces for the sample input and result channels.
interface bbp_in_if #(
    parameter int SAMPLE_WIDTH = bbp_pkg::SAMPLE_WIDTH_DEF
);
    logic                           valid;
    logic                           ready;
    logic signed [SAMPLE_WIDTH-1:0] sample_in;
    logic                           block_start;

    modport source (output valid, output sample_in, output block_start, input ready);
    modport sink   (input valid, input sample_in, input block_start, output ready);
endinterface

interface bbp_out_if #(
    parameter int SAMPLE_WIDTH = bbp_pkg::SAMPLE_WIDTH_DEF
);
    logic                           valid;
    logic                           ready;
    logic signed [SAMPLE_WIDTH-1:0] sample_out;
    logic                           saturated;

    modport source (output valid, output sample_out, output saturated, input ready);
    modport sink   (input valid, input sample_out, input saturated, output ready);
endinterface

[rtl/bbp_regs.sv]
// APB-style coefficient register file.
module bbp_regs (
    input  logic                             clk,
    input  logic                             rst_n,
    input  logic                             psel,
    input  logic                             penable,
    input  logic                             pwrite,
    input  logic [bbp_pkg::PADDR_WIDTH-1:0]  paddr,
    input  logic [bbp_pkg::PDATA_WIDTH-1:0]  pwdata,
    output logic [bbp_pkg::PDATA_WIDTH-1:0]  prdata,
    output logic                             pready,
    output bbp_pkg::coef_t                   coef [bbp_pkg::REG_COUNT]
);
    import bbp_pkg::*;

    coef_t                    coef_reg [REG_COUNT];
    logic                     wr_en;
    logic [REG_IDX_WIDTH-1:0] reg_idx;

    assign pready  = 1'b1;
    assign wr_en   = psel & penable & pwrite;
    assign reg_idx = paddr[PADDR_WIDTH-1:2];

    // Write a coefficient; drop writes beyond the map
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int i = 0; i < REG_COUNT; i++)
            begin
                coef_reg[i] <= '0;
            end
        end
        else if (wr_en)
        begin
            case (reg_idx)
                REG_GAIN:     coef_reg[REG_GAIN]     <= pwdata;
                REG_FB_ONE:   coef_reg[REG_FB_ONE]   <= pwdata;
                REG_FB_TWO:   coef_reg[REG_FB_TWO]   <= pwdata;
                REG_FB_THREE: coef_reg[REG_FB_THREE] <= pwdata;
                REG_FB_FOUR:  coef_reg[REG_FB_FOUR]  <= pwdata;
                default:      ;
            endcase
        end
    end

    // Read back
    always_comb
    begin
        case (reg_idx)
            REG_GAIN:     prdata = coef_reg[REG_GAIN];
            REG_FB_ONE:   prdata = coef_reg[REG_FB_ONE];
            REG_FB_TWO:   prdata = coef_reg[REG_FB_TWO];
            REG_FB_THREE: prdata = coef_reg[REG_FB_THREE];
            REG_FB_FOUR:  prdata = coef_reg[REG_FB_FOUR];
            default:      prdata = '0;
        endcase
    end

    assign coef = coef_reg;

endmodule

[rtl/bbp_ctrl.sv]
// Sequencer: steps the shared multiplier through the ten half products of a sample.
module bbp_ctrl (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              in_valid,
    output logic              in_ready,
    output bbp_pkg::bbp_cmd_t cmd,
    input  bbp_pkg::bbp_sts_t sts
);
    import bbp_pkg::*;

    localparam int CNT_WIDTH = $clog2(2 * TAP_COUNT);
    localparam logic [CNT_WIDTH-1:0] FEED_LAST  = CNT_WIDTH'(2 * TAP_COUNT - 1);
    localparam logic [CNT_WIDTH-1:0] DRAIN_LAST = CNT_WIDTH'(1);
    localparam logic [CNT_WIDTH-1:0] GAIN_LAST  = CNT_WIDTH'(1);

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_FEED,
        ST_DRAIN,
        ST_FINISH,
        ST_WAIT,
        ST_GAIN
    } state_t;

    state_t               state_reg, state_next;
    logic [CNT_WIDTH-1:0] cnt_reg, cnt_next;

    assign in_ready = (state_reg == ST_IDLE);

    // Next state and per-cycle command
    always_comb
    begin
        state_next   = state_reg;
        cnt_next     = cnt_reg;
        cmd          = '0;
        case (state_reg)
            ST_IDLE:
            begin
                if (in_valid)
                begin
                    cmd.load   = 1'b1;
                    state_next = ST_FEED;
                    cnt_next   = '0;
                end
            end
            ST_FEED:
            begin
                cmd.mul_en  = 1'b1;
                cmd.mul_tap = cnt_reg[CNT_WIDTH-1:1];
                cmd.mul_hi  = cnt_reg[0];
                cnt_next    = cnt_reg + 1'b1;
                if (cnt_reg == FEED_LAST)
                begin
                    state_next = ST_DRAIN;
                    cnt_next   = '0;
                end
            end
            ST_DRAIN:
            begin
                cnt_next = cnt_reg + 1'b1;
                if (cnt_reg == DRAIN_LAST)
                begin
                    state_next = ST_FINISH;
                end
            end
            ST_FINISH:
            begin
                cmd.finish = 1'b1;
                state_next = ST_WAIT;
            end
            ST_WAIT:
            begin
                // hold until the result register is free
                if (!sts.out_full)
                begin
                    state_next = ST_GAIN;
                    cnt_next   = '0;
                end
            end
            ST_GAIN:
            begin
                cmd.mul_en   = 1'b1;
                cmd.mul_gain = 1'b1;
                cmd.mul_hi   = cnt_reg[0];
                cnt_next     = cnt_reg + 1'b1;
                if (cnt_reg == GAIN_LAST)
                begin
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // Hold state and counter
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
            cnt_reg   <= '0;
        end
        else
        begin
            state_reg <= state_next;
            cnt_reg   <= cnt_next;
        end
    end

    // A gain product never starts while a result is still waiting
    assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_GAIN) |-> !sts.out_full)
        else $error("gain product issued while result register full");

    // An accepted transaction starts the feedback sweep at its first half product
    assert property (@(posedge clk) disable iff (!rst_n)
        cmd.load |=> (state_reg == ST_FEED) && (cnt_reg == '0))
        else $error("feedback sweep did not start after load");

    // The recursion is closed only after the last feedback product has drained
    assert property (@(posedge clk) disable iff (!rst_n)
        cmd.finish |-> $past(state_reg == ST_DRAIN) && !$past(cmd.mul_en, 2))
        else $error("finish issued before feedback products drained");

endmodule

[rtl/bbp_dp.sv]
// Datapath: delay line, shared split multiplier, accumulator and result register.
module bbp_dp #(
    parameter int SAMPLE_WIDTH = bbp_pkg::SAMPLE_WIDTH_DEF,
    parameter int STATE_WIDTH  = bbp_pkg::STATE_WIDTH_DEF
) (
    input  logic                           clk,
    input  logic                           rst_n,
    input  bbp_pkg::bbp_cmd_t              cmd,
    output bbp_pkg::bbp_sts_t              sts,
    input  bbp_pkg::coef_t                 coef [bbp_pkg::REG_COUNT],
    input  logic signed [SAMPLE_WIDTH-1:0] sample_in,
    input  logic                           block_start,
    input  logic                           out_ready,
    output logic                           out_valid,
    output logic signed [SAMPLE_WIDTH-1:0] sample_out,
    output logic                           saturated
);
    import bbp_pkg::*;

    // Operand covers the difference term new - 2*w2 + w4
    localparam int OP_W   = STATE_WIDTH + 2;
    localparam int LO_W   = OP_W / 2;
    localparam int HI_W   = OP_W - LO_W;
    localparam int PP_W   = COEF_WIDTH + HI_W + 1;
    localparam int PROD_W = COEF_WIDTH + OP_W;
    localparam int TERM_W = PROD_W - COEF_FRAC;
    localparam int ACC_W  = TERM_W + 3;
    localparam int W2_IDX = 1;
    localparam int W4_IDX = 3;

    localparam logic signed [ACC_W-1:0]  ST_MAX = ACC_W'({1'b0, {(STATE_WIDTH-1){1'b1}}});
    localparam logic signed [ACC_W-1:0]  ST_MIN = ~ST_MAX;
    localparam logic signed [TERM_W-1:0] Y_MAX  = TERM_W'({1'b0, {(SAMPLE_WIDTH-1){1'b1}}});
    localparam logic signed [TERM_W-1:0] Y_MIN  = ~Y_MAX;

    logic signed [STATE_WIDTH-1:0]  dl_reg [TAP_COUNT];
    logic signed [ACC_W-1:0]        acc_reg;
    logic signed [OP_W-1:0]         diff_reg;
    logic signed [PP_W-1:0]         pp_reg;
    logic signed [PROD_W-1:0]       prod_reg;
    logic                           t1_valid_reg, t1_hi_reg, t1_gain_reg;
    logic                           t2_done_reg, t2_gain_reg;
    logic                           out_valid_reg;
    logic signed [SAMPLE_WIDTH-1:0] out_sample_reg;
    logic                           out_sat_reg;

    coef_t                          coef_sel;
    logic signed [OP_W-1:0]         op_sel;
    logic signed [HI_W:0]           chunk;
    logic signed [PP_W-1:0]         pp_next;
    logic signed [PROD_W-1:0]       prod_next;
    logic signed [TERM_W-1:0]       term;
    logic signed [STATE_WIDTH-1:0]  new_state;
    logic signed [OP_W-1:0]         diff_next;
    logic signed [SAMPLE_WIDTH-1:0] y_sat;
    logic                           y_clip;
    logic                           capture;

    // Select coefficient and operand half for this issue
    always_comb
    begin
        if (cmd.mul_gain)
        begin
            coef_sel = coef[REG_GAIN];
            op_sel   = diff_reg;
        end
        else
        begin
            coef_sel = coef[REG_IDX_WIDTH'(REG_FB_ONE + REG_IDX_WIDTH'(cmd.mul_tap))];
            op_sel   = OP_W'(dl_reg[cmd.mul_tap]);
        end
        if (cmd.mul_hi)
        begin
            chunk = signed'({op_sel[OP_W-1], op_sel[OP_W-1:LO_W]});
        end
        else
        begin
            chunk = signed'({{(HI_W + 1 - LO_W){1'b0}}, op_sel[LO_W-1:0]});
        end
    end

    assign pp_next = coef_sel * chunk;

    // Combine half products into the exact product
    always_comb
    begin
        if (t1_hi_reg)
        begin
            prod_next = prod_reg + (PROD_W'(pp_reg) <<< LO_W);
        end
        else
        begin
            prod_next = PROD_W'(pp_reg);
        end
    end

    // Floor of product over 2^COEF_FRAC is the arithmetic shift
    assign term = signed'(prod_reg[PROD_W-1:COEF_FRAC]);

    // Saturate the recursion sum into the state range
    always_comb
    begin
        if (acc_reg > ST_MAX)
        begin
            new_state = STATE_WIDTH'(ST_MAX);
        end
        else if (acc_reg < ST_MIN)
        begin
            new_state = STATE_WIDTH'(ST_MIN);
        end
        else
        begin
            new_state = acc_reg[STATE_WIDTH-1:0];
        end
    end

    assign diff_next = OP_W'(new_state) - (OP_W'(dl_reg[W2_IDX]) <<< 1) + OP_W'(dl_reg[W4_IDX]);

    // Saturate the output sample
    always_comb
    begin
        y_clip = 1'b1;
        if (term > Y_MAX)
        begin
            y_sat = SAMPLE_WIDTH'(Y_MAX);
        end
        else if (term < Y_MIN)
        begin
            y_sat = SAMPLE_WIDTH'(Y_MIN);
        end
        else
        begin
            y_sat  = term[SAMPLE_WIDTH-1:0];
            y_clip = 1'b0;
        end
    end

    assign capture = t2_done_reg & t2_gain_reg;

    // Control tags, delay line, accumulator and result valid
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            t1_valid_reg  <= 1'b0;
            t1_hi_reg     <= 1'b0;
            t1_gain_reg   <= 1'b0;
            t2_done_reg   <= 1'b0;
            t2_gain_reg   <= 1'b0;
            out_valid_reg <= 1'b0;
            acc_reg       <= '0;
            for (int i = 0; i < TAP_COUNT; i++)
            begin
                dl_reg[i] <= '0;
            end
        end
        else
        begin
            t1_valid_reg <= cmd.mul_en;
            t1_hi_reg    <= cmd.mul_hi;
            t1_gain_reg  <= cmd.mul_gain;
            t2_done_reg  <= t1_valid_reg & t1_hi_reg;
            t2_gain_reg  <= t1_gain_reg;

            // load the sample, clear the delay line at a block start
            if (cmd.load)
            begin
                acc_reg <= ACC_W'(sample_in);
                if (block_start)
                begin
                    for (int i = 0; i < TAP_COUNT; i++)
                    begin
                        dl_reg[i] <= '0;
                    end
                end
            end
            else if (t2_done_reg && !t2_gain_reg)
            begin
                acc_reg <= acc_reg + ACC_W'(term);
            end

            // advance the delay line
            if (cmd.finish)
            begin
                for (int i = TAP_COUNT - 1; i > 0; i--)
                begin
                    dl_reg[i] <= dl_reg[i-1];
                end
                dl_reg[0] <= new_state;
            end

            if (capture)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (out_ready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    // Payload registers
    always_ff @(posedge clk)
    begin
        if (cmd.mul_en)
        begin
            pp_reg <= pp_next;
        end
        if (t1_valid_reg)
        begin
            prod_reg <= prod_next;
        end
        if (cmd.finish)
        begin
            diff_reg <= diff_next;
        end
        if (capture)
        begin
            out_sample_reg <= y_sat;
            out_sat_reg    <= y_clip;
        end
    end

    assign sts.out_full = out_valid_reg;
    assign out_valid    = out_valid_reg;
    assign sample_out   = out_sample_reg;
    assign saturated    = out_sat_reg;

    // A finished result never lands on one still waiting
    assert property (@(posedge clk) disable iff (!rst_n)
        capture |-> !out_valid_reg)
        else $error("result register overwritten");

    // Upper half issue directly follows its lower half for the same product
    assert property (@(posedge clk) disable iff (!rst_n)
        (cmd.mul_en && cmd.mul_hi) |-> (t1_valid_reg && !t1_hi_reg && t1_gain_reg == cmd.mul_gain))
        else $error("upper half product without matching lower half");

    // Feedback terms are not still draining when a new sample loads
    assert property (@(posedge clk) disable iff (!rst_n)
        cmd.load |-> !(t1_valid_reg && !t1_gain_reg) && !(t2_done_reg && !t2_gain_reg))
        else $error("load collides with accumulator update");

endmodule

[rtl/butterworth_bandpass_iir.sv]
// Fourth-order band-pass IIR section: register file, sequencer and datapath.
//
// One direct form II section: new = d1*w1 + d2*w2 + d3*w3 + d4*w4 + x, saturated to the state
// width, and y = A*(new - 2*w2 + w4), saturated to the sample width with the saturated flag set
// on clipping. Each product is exact and floored by 2^28. A sample is processed as ten half
// products (four feedback taps and the gain, each split over the operand's two halves) on a
// single shared 32 by 22 bit multiplier. After acceptance the sequencer issues the feedback
// half products, drains them into the accumulator, closes the recursion, waits until the
// result register is free and then issues the gain half products. The gain halves pass
// through the half product and product registers, and the saturated result is then loaded
// into the result register, whose valid drives the port. Input is accepted again while a
// result still waits, and a new gain product is held off until that result is taken.
// Registers (APB, 32-bit, byte address 4*index): 0 gain A, 1..4 feedback d1..d4, all signed
// Q4.28, reset to zero; block_start clears the delay line before its sample is processed.
module butterworth_bandpass_iir #(
    parameter int SAMPLE_WIDTH = bbp_pkg::SAMPLE_WIDTH_DEF,
    parameter int STATE_WIDTH  = bbp_pkg::STATE_WIDTH_DEF
) (
    input  logic                            clk,
    input  logic                            rst_n,
    bbp_in_if.sink                          in_ch,
    bbp_out_if.source                       out_ch,
    input  logic                            psel,
    input  logic                            penable,
    input  logic                            pwrite,
    input  logic [bbp_pkg::PADDR_WIDTH-1:0] paddr,
    input  logic [bbp_pkg::PDATA_WIDTH-1:0] pwdata,
    output logic [bbp_pkg::PDATA_WIDTH-1:0] prdata,
    output logic                            pready
);
    import bbp_pkg::*;

    coef_t                          coef [REG_COUNT];
    bbp_cmd_t                       cmd;
    bbp_sts_t                       sts;
    logic                           in_ready;
    logic                           out_valid;
    logic signed [SAMPLE_WIDTH-1:0] sample_out;
    logic                           saturated;

    bbp_regs u_regs (
        .clk     (clk),
        .rst_n   (rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .coef    (coef)
    );

    bbp_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (in_ch.valid),
        .in_ready (in_ready),
        .cmd      (cmd),
        .sts      (sts)
    );

    bbp_dp #(
        .SAMPLE_WIDTH (SAMPLE_WIDTH),
        .STATE_WIDTH  (STATE_WIDTH)
    ) u_dp (
        .clk         (clk),
        .rst_n       (rst_n),
        .cmd         (cmd),
        .sts         (sts),
        .coef        (coef),
        .sample_in   (SAMPLE_WIDTH'(in_ch.sample_in)),
        .block_start (in_ch.block_start),
        .out_ready   (out_ch.ready),
        .out_valid   (out_valid),
        .sample_out  (sample_out),
        .saturated   (saturated)
    );

    // Drive the channel handshakes
    assign in_ch.ready       = in_ready;
    assign out_ch.valid      = out_valid;
    assign out_ch.sample_out = sample_out;
    assign out_ch.saturated  = saturated;

endmodule
